@@ hdl/lltstat_pkg.sv @@
package lltstat_pkg;

  // line timing
  localparam logic [7:0] VISIBLE_LINES = 8'd160;
  localparam logic [8:0] TOTAL_LINES   = 9'd228;

  // status register bit positions
  localparam int unsigned ST_VBLANK_BIT   = 0;
  localparam int unsigned ST_HBLANK_BIT   = 1;
  localparam int unsigned ST_MATCH_BIT    = 2;
  localparam int unsigned ST_VBL_IE_BIT   = 3;
  localparam int unsigned ST_HBL_IE_BIT   = 4;
  localparam int unsigned ST_MATCH_IE_BIT = 5;

  // writable bits per write kind
  localparam logic [15:0] WR_MASK_HALF = 16'hFFB8;
  localparam logic [15:0] WR_MASK_LOW  = 16'h00B8;
  localparam logic [15:0] WR_MASK_HIGH = 16'hFF00;

  typedef enum logic [2:0] {
    OP_HBLANK   = 3'd0,
    OP_LINE_END = 3'd1,
    OP_WR_HALF  = 3'd2,
    OP_WR_LOW   = 3'd3,
    OP_WR_HIGH  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_WIN0_TOP    = 2'd0,
    CFG_WIN0_BOTTOM = 2'd1,
    CFG_WIN1_TOP    = 2'd2,
    CFG_WIN1_BOTTOM = 2'd3
  } cfg_idx_t;

endpackage

@@ hdl/lcd_line_timing_status_core.sv @@
// Display line timing and status core. Each request carries an hblank-start
// event, a line-end event or a status register write (halfword, low byte, high
// byte) and yields one result: the status word, the line count, the interrupt
// requests raised by that request, the vertical window flags and a render flag.
// A request is first captured in an input register; a single pass of compare
// and bit-update logic then computes the new line state and loads the result
// register once it can take a result. One request per cycle is accepted while
// in_stall is low. A result held by out_stall keeps the captured request in
// the input register, which then stalls the next request. Window registers are
// to be written through the cfg port only while no request is in flight; the
// block itself does not enforce this.
module lcd_line_timing_status_core
  import lltstat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_write_data,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_status_word,
  output logic [7:0]  out_line_count,
  output logic        out_irq_hblank,
  output logic        out_irq_vblank,
  output logic        out_irq_line_match,
  output logic        out_win0_active,
  output logic        out_win1_active,
  output logic        out_render_line
);

  // window configuration
  logic [7:0] win0_top_r, win0_bottom_r, win1_top_r, win1_bottom_r;

  // line state
  logic [15:0] status_r, status_nxt;
  logic [7:0]  line_r, line_nxt;
  logic        win0_r, win0_nxt;
  logic        win1_r, win1_nxt;

  // input register
  logic        in_valid_r;
  logic [2:0]  op_r;
  logic [15:0] data_r;

  // result register
  logic        out_valid_r;
  logic [15:0] out_status_r;
  logic [7:0]  out_line_r;
  logic        out_irq_h_r, out_irq_v_r, out_irq_m_r;
  logic        out_win0_r, out_win1_r, out_render_r;

  // per-request combinational results
  logic irq_h, irq_v, irq_m, render;

  logic out_adv;   // result register can take a new result
  logic step;      // captured request is processed this cycle

  assign out_adv  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;

  // single-pass update of the line state for the captured request
  always_comb begin
    logic [8:0] line_inc;
    logic [8:0] line_plus2;
    logic       match_eval;
    status_nxt = status_r;
    line_nxt   = line_r;
    win0_nxt   = win0_r;
    win1_nxt   = win1_r;
    irq_h      = 1'b0;
    irq_v      = 1'b0;
    irq_m      = 1'b0;
    render     = 1'b0;
    match_eval = 1'b0;
    line_inc   = {1'b0, line_r} + 9'd1;
    line_plus2 = 9'd0;
    case (op_r)
      OP_HBLANK: begin
        status_nxt[ST_HBLANK_BIT] = 1'b1;
        irq_h  = status_r[ST_HBL_IE_BIT];
        render = (line_r < VISIBLE_LINES);
      end
      OP_LINE_END: begin
        // wrap at end of frame
        line_nxt   = (line_inc >= TOTAL_LINES) ? 8'd0 : line_inc[7:0];
        line_plus2 = {1'b0, line_nxt} + 9'd2;
        status_nxt[ST_HBLANK_BIT] = 1'b0;
        status_nxt[ST_VBLANK_BIT] = (line_nxt >= VISIBLE_LINES) && (line_plus2 <= TOTAL_LINES);
        irq_v = (line_nxt == VISIBLE_LINES) && status_r[ST_VBL_IE_BIT];
        match_eval = 1'b1;
        // bottom wins over top on the same line
        if (line_nxt == win1_bottom_r) begin
          win1_nxt = 1'b0;
        end else if (line_nxt == win1_top_r) begin
          win1_nxt = 1'b1;
        end
        if (line_nxt == win0_bottom_r) begin
          win0_nxt = 1'b0;
        end else if (line_nxt == win0_top_r) begin
          win0_nxt = 1'b1;
        end
      end
      OP_WR_HALF: begin
        status_nxt = (status_r & ~WR_MASK_HALF) | (data_r & WR_MASK_HALF);
        match_eval = (status_nxt[15:8] != status_r[15:8]);
      end
      OP_WR_LOW: begin
        status_nxt = (status_r & ~WR_MASK_LOW) | ({8'd0, data_r[7:0]} & WR_MASK_LOW);
      end
      OP_WR_HIGH: begin
        status_nxt = (status_r & ~WR_MASK_HIGH) | {data_r[7:0], 8'd0};
        match_eval = (status_nxt[15:8] != status_r[15:8]);
      end
      default: begin
        // unused opcodes leave the state alone
      end
    endcase
    // line-match re-evaluation
    if (match_eval) begin
      if (line_nxt == status_nxt[15:8]) begin
        status_nxt[ST_MATCH_BIT] = 1'b1;
        irq_m = status_nxt[ST_MATCH_IE_BIT];
      end else begin
        status_nxt[ST_MATCH_BIT] = 1'b0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_top_r    <= '0;
      win0_bottom_r <= '0;
      win1_top_r    <= '0;
      win1_bottom_r <= '0;
      status_r      <= '0;
      line_r        <= '0;
      win0_r        <= 1'b0;
      win1_r        <= 1'b0;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIN0_TOP:    win0_top_r    <= cfg_data;
          CFG_WIN0_BOTTOM: win0_bottom_r <= cfg_data;
          CFG_WIN1_TOP:    win1_top_r    <= cfg_data;
          CFG_WIN1_BOTTOM: win1_bottom_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (step) begin
        status_r <= status_nxt;
        line_r   <= line_nxt;
        win0_r   <= win0_nxt;
        win1_r   <= win1_nxt;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      op_r   <= in_opcode;
      data_r <= in_write_data;
    end
    if (step) begin
      out_status_r <= status_nxt;
      out_line_r   <= line_nxt;
      out_irq_h_r  <= irq_h;
      out_irq_v_r  <= irq_v;
      out_irq_m_r  <= irq_m;
      out_win0_r   <= win0_nxt;
      out_win1_r   <= win1_nxt;
      out_render_r <= render;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status_word    = out_status_r;
  assign out_line_count     = out_line_r;
  assign out_irq_hblank     = out_irq_h_r;
  assign out_irq_vblank     = out_irq_v_r;
  assign out_irq_line_match = out_irq_m_r;
  assign out_win0_active    = out_win0_r;
  assign out_win1_active    = out_win1_r;
  assign out_render_line    = out_render_r;

endmodule

@@ hdl/lltstat_checker.sv @@
module lltstat_checker
  import lltstat_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_status_word,
  input logic [7:0]  out_line_count,
  input logic        out_irq_hblank,
  input logic        out_irq_vblank,
  input logic        out_irq_line_match,
  input logic        out_render_line
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_word)
      && $stable(out_line_count))
    else $error("stalled result changed");

  // vblank request only on entry to the first blank line
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_vblank |->
      out_line_count == VISIBLE_LINES && out_status_word[ST_VBLANK_BIT]
      && out_status_word[ST_VBL_IE_BIT])
    else $error("vblank request off its line");

  // line-match request agrees with the flag and the match line
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_line_match |->
      out_status_word[ST_MATCH_BIT] && out_status_word[ST_MATCH_IE_BIT]
      && out_status_word[15:8] == out_line_count)
    else $error("line-match request without match");

  // render only during hblank on a visible line, with the hblank request following its enable
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_render_line |->
      out_status_word[ST_HBLANK_BIT] && out_line_count < VISIBLE_LINES
      && out_irq_hblank == out_status_word[ST_HBL_IE_BIT])
    else $error("render flag outside visible hblank");

endmodule

bind lcd_line_timing_status_core lltstat_checker u_lltstat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status_word    (out_status_word),
  .out_line_count     (out_line_count),
  .out_irq_hblank     (out_irq_hblank),
  .out_irq_vblank     (out_irq_vblank),
  .out_irq_line_match (out_irq_line_match),
  .out_render_line    (out_render_line)
);

@@ tb/tb_lcd_line_timing_status_core.sv @@
`timescale 1ns / 1ps

module tb_lcd_line_timing_status_core;
  import lltstat_pkg::*;

  // unused opcodes: the block must leave its state alone on these
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int CYCLE_LIMIT    = 100000;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] data;
  } status_req_t;

  typedef struct packed {
    logic [15:0] status_word;
    logic [7:0]  line_count;
    logic        irq_hblank;
    logic        irq_vblank;
    logic        irq_match;
    logic        win0;
    logic        win1;
    logic        render;
  } line_status_t;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_WIN0_TOP;
  logic [7:0]  cfg_data = 8'h00;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = OP_HBLANK;
  logic [15:0] in_write_data = 16'h0000;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_status_word;
  logic [7:0]  out_line_count;
  logic        out_irq_hblank;
  logic        out_irq_vblank;
  logic        out_irq_line_match;
  logic        out_win0_active;
  logic        out_win1_active;
  logic        out_render_line;

  // requests waiting to be offered, and predicted results waiting to come back
  status_req_t  pending_reqs[$];
  line_status_t expected_status[$];

  // predicted copy of the block's line state and window registers
  logic [15:0] lcd_status;
  logic [7:0]  scan_line;
  logic        win0_on;
  logic        win1_on;
  logic [7:0]  window_cfg[4];

  // line number the queued stimulus will have reached, used to aim match writes
  int          gen_line;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int          hold_left;
  int          mismatch_count;
  int          cycle_count;

  lcd_line_timing_status_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status_word   (out_status_word),
    .out_line_count    (out_line_count),
    .out_irq_hblank    (out_irq_hblank),
    .out_irq_vblank    (out_irq_vblank),
    .out_irq_line_match(out_irq_line_match),
    .out_win0_active   (out_win0_active),
    .out_win1_active   (out_win1_active),
    .out_render_line   (out_render_line)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // line state predictor
  // ---------------------------------------------------------------------------

  // compare line counter with the match line, update the flag, return the irq
  function automatic logic refresh_match();
    if (scan_line == lcd_status[15:8]) begin
      lcd_status[ST_MATCH_BIT] = 1'b1;
      return lcd_status[ST_MATCH_IE_BIT];
    end
    lcd_status[ST_MATCH_BIT] = 1'b0;
    return 1'b0;
  endfunction

  function automatic line_status_t predict_line_status(logic [2:0] op, logic [15:0] data);
    line_status_t r;
    logic [15:0]  prev;
    logic [15:0]  mask;
    logic [15:0]  val;
    int           next_line;
    r = '0;
    case (op)
      OP_HBLANK: begin
        lcd_status[ST_HBLANK_BIT] = 1'b1;
        r.irq_hblank = lcd_status[ST_HBL_IE_BIT];
        r.render     = (scan_line < VISIBLE_LINES);
      end
      OP_LINE_END: begin
        // counter wraps after the last line of the frame
        next_line = int'(scan_line) + 1;
        if (next_line >= int'(TOTAL_LINES))
          next_line = 0;
        scan_line = next_line[7:0];
        lcd_status[ST_HBLANK_BIT] = 1'b0;
        // vblank covers the invisible lines except the very last one
        lcd_status[ST_VBLANK_BIT] = (next_line >= int'(VISIBLE_LINES)) &&
                                    (next_line + 2 <= int'(TOTAL_LINES));
        r.irq_vblank = (next_line == int'(VISIBLE_LINES)) && lcd_status[ST_VBL_IE_BIT];
        r.irq_match  = refresh_match();
        // bottom wins when top and bottom are the same line
        if (scan_line == window_cfg[CFG_WIN1_TOP])    win1_on = 1'b1;
        if (scan_line == window_cfg[CFG_WIN1_BOTTOM]) win1_on = 1'b0;
        if (scan_line == window_cfg[CFG_WIN0_TOP])    win0_on = 1'b1;
        if (scan_line == window_cfg[CFG_WIN0_BOTTOM]) win0_on = 1'b0;
      end
      OP_WR_HALF, OP_WR_LOW, OP_WR_HIGH: begin
        prev = lcd_status;
        if (op == OP_WR_HALF) begin
          mask = WR_MASK_HALF;
          val  = data & WR_MASK_HALF;
        end else if (op == OP_WR_LOW) begin
          mask = WR_MASK_LOW;
          val  = {8'h00, data[7:0]} & WR_MASK_LOW;
        end else begin
          mask = WR_MASK_HIGH;
          val  = {data[7:0], 8'h00};
        end
        lcd_status = (prev & ~mask) | val;
        // match is only looked at again when the match line really changes
        if (prev[15:8] != lcd_status[15:8])
          r.irq_match = refresh_match();
      end
      default: ;
    endcase
    r.status_word = lcd_status;
    r.line_count  = scan_line;
    r.win0        = win0_on;
    r.win1        = win1_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(logic [2:0] op, logic [15:0] data);
    pending_reqs.push_back('{opcode: op, data: data});
    if (op == OP_LINE_END)
      gen_line = (gen_line >= int'(TOTAL_LINES) - 1) ? 0 : gen_line + 1;
  endtask

  // mostly scanline traffic (hblank and line end) with writes and unused opcodes sprinkled in;
  // some high-byte writes aim the match line at the current or next line
  task automatic queue_random_requests(int count);
    int          pick;
    logic [7:0]  target;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        queue_request(OP_LINE_END, 16'($urandom));
      else if (pick < 72)
        queue_request(OP_HBLANK, 16'($urandom));
      else if (pick < 80)
        queue_request(OP_WR_HALF, 16'($urandom));
      else if (pick < 85)
        queue_request(OP_WR_LOW, 16'($urandom));
      else if (pick < 89)
        queue_request(OP_WR_HIGH, 16'($urandom));
      else if (pick < 96) begin
        target = 8'((gen_line + $urandom_range(0, 1)) % int'(TOTAL_LINES));
        queue_request(OP_WR_HIGH, {8'($urandom), target});
      end else
        queue_request(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 16'($urandom));
    end
  endtask

  task automatic write_window_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    window_cfg[idx] = val;
  endtask

  // only called while nothing is in flight
  task automatic program_windows(logic [7:0] t0, logic [7:0] b0, logic [7:0] t1,
                                 logic [7:0] b1);
    write_window_reg(CFG_WIN0_TOP,    t0);
    write_window_reg(CFG_WIN0_BOTTOM, b0);
    write_window_reg(CFG_WIN1_TOP,    t1);
    write_window_reg(CFG_WIN1_BOTTOM, b1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds back until every predicted result has been seen
  task automatic wait_for_drain();
    do
      @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: accepted requests are predicted at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    status_req_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_status.push_back(predict_line_status(in_opcode, in_write_data));
      // a stalled request stays put; otherwise offer the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= nxt.opcode;
          in_write_data <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side stall: random idling plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_stall
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: oldest prediction against each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    line_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_status_word, 16'h0000);
      end else begin
        want = expected_status.pop_front();
        check_field("status_word", out_status_word, want.status_word);
        check_field("line_count", 16'(out_line_count), 16'(want.line_count));
        check_field("irq_hblank", 16'(out_irq_hblank), 16'(want.irq_hblank));
        check_field("irq_vblank", 16'(out_irq_vblank), 16'(want.irq_vblank));
        check_field("irq_line_match", 16'(out_irq_line_match), 16'(want.irq_match));
        check_field("win0_active", 16'(out_win0_active), 16'(want.win0));
        check_field("win1_active", 16'(out_win1_active), 16'(want.win1));
        check_field("render_line", 16'(out_render_line), 16'(want.render));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    lcd_status     = '0;
    scan_line      = '0;
    win0_on        = 1'b0;
    win1_on        = 1'b0;
    window_cfg     = '{default: 8'h00};
    gen_line       = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // small windows near the top, window one with top equal to bottom
    program_windows(8'd2, 8'd5, 8'd3, 8'd3);

    // phase one: sender idles rarely, receiver idles most of the time
    send_idle_pct = 14;
    recv_idle_pct = 86;

    // directed: flags, masks, match on write and on line end, unused opcodes
    queue_request(OP_HBLANK,   16'h0000);  // visible line, irq disabled, render
    queue_request(OP_WR_HALF,  16'hFFFF);  // all writable bits, match line 255
    queue_request(OP_HBLANK,   16'h0000);  // hblank irq now enabled
    queue_request(OP_WR_HIGH,  16'h0001);  // match line moves to 1, no match yet
    queue_request(OP_LINE_END, 16'hFFFF);  // line 1 hits match with irq enabled
    queue_request(OP_WR_LOW,   16'h00FF);  // read-only low bits must survive
    queue_request(OP_WR_LOW,   16'h0000);  // enables off
    queue_request(OP_WR_HIGH,  16'hFF01);  // only low byte used, match line unchanged
    queue_request(OP_WR_HALF,  16'h0100);  // high byte same, no re-evaluation
    queue_request(OP_WR_HIGH,  16'h0000);  // match line to 0, flag clears
    queue_request(OP_WR_HIGH,  16'h0001);  // match on write with irq disabled
    queue_request(OP_WR_HALF,  16'h0120);  // enable set, high byte same, no irq
    queue_request(OP_SPARE_FIRST, 16'hFFFF);
    queue_request(OP_SPARE_MID,   16'h5A5A);
    queue_request(OP_SPARE_LAST,  16'hA5A5);
    queue_request(OP_WR_HALF,  16'h0000);
    for (int i = 0; i < 6; i++)
      queue_request(OP_LINE_END, 16'h0000);  // walk through both window edges

    queue_random_requests(190);
    wait_for_drain();

    // phase two: extreme window lines, the other idling mix
    program_windows(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_idle_pct = 86;
    recv_idle_pct = 14;
    queue_random_requests(180);
    wait_for_drain();

    // phase three: random windows, no idling, plus a long receiver hold-off so
    // requests back up into the block and the input side stalls
    program_windows(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(180);
    hold_request = 1'b1;
    wait_for_drain();

    if (mismatch_count == 0 && expected_status.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ lcd_line_timing_status_core.f @@
hdl/lltstat_pkg.sv
hdl/lcd_line_timing_status_core.sv
hdl/lltstat_checker.sv
tb/tb_lcd_line_timing_status_core.sv
